// File: sv/flvp_pkg.sv
package flvp_pkg;

  localparam int CNT_W    = 24;
  localparam int LEN_W    = 24;
  localparam int TIME_W   = 32;
  localparam int OFFSET_W = 40;
  localparam int COUNT_W  = 32;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TYPE,
    PH_LENGTH,
    PH_TIME,
    PH_STREAM,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [1:0] {
    KIND_AUDIO   = 2'd0,
    KIND_VIDEO   = 2'd1,
    KIND_SCRIPT  = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  // tag type byte codes
  localparam logic [7:0] TYPE_AUDIO  = 8'd8;
  localparam logic [7:0] TYPE_VIDEO  = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;

  // byte counts of the fixed fields (file header plus first previous-tag size)
  localparam logic [CNT_W-1:0] HEADER_SKIP_BYTES = 24'd13;
  localparam logic [CNT_W-1:0] LENGTH_BYTES      = 24'd3;
  localparam logic [CNT_W-1:0] TIME_LOW_BYTES    = 24'd3;
  localparam logic [CNT_W-1:0] TIME_BYTES        = 24'd4;
  localparam logic [CNT_W-1:0] STREAM_BYTES      = 24'd3;
  localparam logic [CNT_W-1:0] TRAILER_BYTES     = 24'd4;

  localparam logic [3:0] AAC_SOUND_FORMAT = 4'd10;
  localparam logic [3:0] AVC_CODEC_ID     = 4'd7;
  localparam logic [3:0] KEY_FRAME_TYPE   = 4'd1;
  localparam logic [7:0] SEQ_HEADER_BYTE  = 8'd0;

  typedef struct packed {
    kind_t               kind;
    logic [LEN_W-1:0]    length;
    logic [TIME_W-1:0]   abs_time;
    logic [OFFSET_W-1:0] offset;
    logic                key;
    logic                hdr;
    logic [COUNT_W-1:0]  audio_cnt;
    logic [COUNT_W-1:0]  video_cnt;
  } tag_rec_t;

endpackage

// File: sv/flvp_ifs.sv
interface flvp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source(output valid, output data_byte, output start_of_file, input ready);
  modport sink(input valid, input data_byte, input start_of_file, output ready);
endinterface

interface flvp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  tag_kind;
  logic [23:0] payload_length;
  logic [31:0] absolute_time;
  logic [39:0] payload_offset;
  logic        is_key_frame;
  logic        is_codec_header;
  logic [31:0] audio_tag_count;
  logic [31:0] video_tag_count;

  modport source(output valid, output tag_kind, output payload_length, output absolute_time,
                 output payload_offset, output is_key_frame, output is_codec_header,
                 output audio_tag_count, output video_tag_count, input ready);
  modport sink(input valid, input tag_kind, input payload_length, input absolute_time,
               input payload_offset, input is_key_frame, input is_codec_header,
               input audio_tag_count, input video_tag_count, output ready);
endinterface

// File: sv/flvp_core.sv
module flvp_core #(
  parameter int OFFSET_BITS = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_of_file,
  output logic              rec_valid,
  output flvp_pkg::tag_rec_t rec
);
  import flvp_pkg::*;

  phase_t                 phase_r, phase_nxt, phase_e;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt, cnt_e, cnt_inc;
  kind_t                  kind_r, kind_nxt, kind_e;
  logic [LEN_W-1:0]       len_r, len_nxt, len_e;
  logic [TIME_W-1:0]      time_r, time_nxt, time_e;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_e;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt, pstart_e;
  logic [7:0]             b0_r, b0_nxt, b0_e;
  logic [7:0]             b1_r, b1_nxt, b1_e;
  logic [COUNT_W-1:0]     acnt_r, acnt_nxt, acnt_e;
  logic [COUNT_W-1:0]     vcnt_r, vcnt_nxt, vcnt_e;
  logic                   halt_r, halt_nxt, halt_e;
  logic                   produce;
  logic                   key, hdr;

  always_comb begin
    // a start of file restarts the parser before the byte is used
    if (start_of_file) begin
      phase_e  = PH_HEADER;
      cnt_e    = '0;
      kind_e   = KIND_AUDIO;
      len_e    = '0;
      time_e   = '0;
      pos_e    = '0;
      pstart_e = '0;
      b0_e     = '0;
      b1_e     = '0;
      acnt_e   = '0;
      vcnt_e   = '0;
      halt_e   = 1'b0;
    end else begin
      phase_e  = phase_r;
      cnt_e    = cnt_r;
      kind_e   = kind_r;
      len_e    = len_r;
      time_e   = time_r;
      pos_e    = pos_r;
      pstart_e = pstart_r;
      b0_e     = b0_r;
      b1_e     = b1_r;
      acnt_e   = acnt_r;
      vcnt_e   = vcnt_r;
      halt_e   = halt_r;
    end

    cnt_inc    = cnt_e + 1'b1;
    phase_nxt  = phase_e;
    cnt_nxt    = cnt_e;
    kind_nxt   = kind_e;
    len_nxt    = len_e;
    time_nxt   = time_e;
    pos_nxt    = pos_e;
    pstart_nxt = pstart_e;
    b0_nxt     = b0_e;
    b1_nxt     = b1_e;
    acnt_nxt   = acnt_e;
    vcnt_nxt   = vcnt_e;
    halt_nxt   = halt_e;
    produce    = 1'b0;
    key        = 1'b0;
    hdr        = 1'b0;

    unique case (kind_e)
      KIND_AUDIO: begin
        key = 1'b1;
        hdr = (b0_e[7:4] == AAC_SOUND_FORMAT) && (b1_e == SEQ_HEADER_BYTE);
      end
      KIND_VIDEO: begin
        key = (b0_e[7:4] == KEY_FRAME_TYPE);
        hdr = key && (b0_e[3:0] == AVC_CODEC_ID) && (b1_e == SEQ_HEADER_BYTE);
      end
      default: begin
        key = 1'b0;
        hdr = 1'b0;
      end
    endcase

    rec.kind      = kind_e;
    rec.length    = len_e;
    rec.abs_time  = hdr ? '0 : time_e;
    rec.offset    = OFFSET_W'(pstart_e);
    rec.key       = key;
    rec.hdr       = hdr;
    rec.audio_cnt = acnt_e;
    rec.video_cnt = vcnt_e;

    if (!halt_e) begin
      pos_nxt = pos_e + 1'b1;
      unique case (phase_e)
        PH_HEADER: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == HEADER_SKIP_BYTES) begin
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
          end
        end
        PH_TYPE: begin
          cnt_nxt  = '0;
          len_nxt  = '0;
          time_nxt = '0;
          priority if (data_byte == TYPE_AUDIO) begin
            kind_nxt  = KIND_AUDIO;
            acnt_nxt  = acnt_e + 1'b1;
            phase_nxt = PH_LENGTH;
          end else if (data_byte == TYPE_VIDEO) begin
            kind_nxt  = KIND_VIDEO;
            vcnt_nxt  = vcnt_e + 1'b1;
            phase_nxt = PH_LENGTH;
          end else if (data_byte == TYPE_SCRIPT) begin
            kind_nxt  = KIND_SCRIPT;
            phase_nxt = PH_LENGTH;
          end else begin
            // unknown type: error record, then halt until the next file
            len_nxt      = len_e;
            time_nxt     = time_e;
            cnt_nxt      = cnt_e;
            halt_nxt     = 1'b1;
            produce      = 1'b1;
            rec.kind     = KIND_INVALID;
            rec.length   = '0;
            rec.abs_time = '0;
            rec.offset   = OFFSET_W'(pos_e);
            rec.key      = 1'b0;
            rec.hdr      = 1'b0;
          end
        end
        PH_LENGTH: begin
          len_nxt = {len_e[LEN_W-9:0], data_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc == LENGTH_BYTES) begin
            phase_nxt = PH_TIME;
            cnt_nxt   = '0;
          end
        end
        PH_TIME: begin
          if (cnt_e < TIME_LOW_BYTES) begin
            time_nxt = {8'd0, time_e[15:0], data_byte};
          end else begin
            time_nxt = {data_byte, time_e[23:0]};
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == TIME_BYTES) begin
            phase_nxt = PH_STREAM;
            cnt_nxt   = '0;
          end
        end
        PH_STREAM: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == STREAM_BYTES) begin
            b0_nxt     = '0;
            b1_nxt     = '0;
            cnt_nxt    = '0;
            // next byte is the first payload byte, or the trailer when the length is zero
            pstart_nxt = pos_e + 1'b1;
            phase_nxt  = (len_e == '0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (cnt_e == '0) begin
            b0_nxt = data_byte;
          end
          if (cnt_e == CNT_W'(1)) begin
            b1_nxt = data_byte;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == len_e) begin
            phase_nxt = PH_TRAILER;
            cnt_nxt   = '0;
          end
        end
        PH_TRAILER: begin
          cnt_nxt = cnt_inc;
          if (cnt_inc == TRAILER_BYTES) begin
            produce   = 1'b1;
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  assign rec_valid = accept && produce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      cnt_r    <= '0;
      kind_r   <= KIND_AUDIO;
      len_r    <= '0;
      time_r   <= '0;
      pos_r    <= '0;
      pstart_r <= '0;
      b0_r     <= '0;
      b1_r     <= '0;
      acnt_r   <= '0;
      vcnt_r   <= '0;
      halt_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      kind_r   <= kind_nxt;
      len_r    <= len_nxt;
      time_r   <= time_nxt;
      pos_r    <= pos_nxt;
      pstart_r <= pstart_nxt;
      b0_r     <= b0_nxt;
      b1_r     <= b1_nxt;
      acnt_r   <= acnt_nxt;
      vcnt_r   <= vcnt_nxt;
      halt_r   <= halt_nxt;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && halt_r && !start_of_file |-> !rec_valid)
    else $error("record produced while halted");

  a_header_silent: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (start_of_file || phase_r == PH_HEADER) |-> !rec_valid)
    else $error("record produced during file header");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r && !(accept && start_of_file) |=> halt_r)
    else $error("halt left without start of file");

endmodule

// File: sv/flv_tag_header_parser.sv
// FLV tag header parser. Takes one file byte per clock on in_ch and gives one
// record per tag on out_ch; the record appears the cycle after the last byte of
// the tag's trailing size is transferred, and an error record the cycle after a
// bad type byte, after which input bytes are ignored until start_of_file. Every
// byte goes through a single state update between the input handshake and the
// record register, so a byte is taken every cycle while out_ch is not stalled;
// input stalls only while a finished record waits in the record register and
// out_ch is not ready. No clearing pass after reset. payload_offset wraps at
// 2^OFFSET_BITS.
module flv_tag_header_parser #(
  parameter int OFFSET_BITS = 40
) (
  input  logic clk,
  input  logic rst_n,
  flvp_in_if.sink    in_ch,
  flvp_out_if.source out_ch
);
  import flvp_pkg::*;

  logic     accept;
  logic     rec_valid;
  tag_rec_t rec;
  tag_rec_t rec_r;
  logic     out_valid_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  flvp_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_ch.data_byte),
    .start_of_file(in_ch.start_of_file),
    .rec_valid    (rec_valid),
    .rec          (rec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= rec_valid;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid) begin
      rec_r <= rec;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.tag_kind        = rec_r.kind;
  assign out_ch.payload_length  = rec_r.length;
  assign out_ch.absolute_time   = rec_r.abs_time;
  assign out_ch.payload_offset  = rec_r.offset;
  assign out_ch.is_key_frame    = rec_r.key;
  assign out_ch.is_codec_header = rec_r.hdr;
  assign out_ch.audio_tag_count = rec_r.audio_cnt;
  assign out_ch.video_tag_count = rec_r.video_cnt;

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_valid_r)
    else $error("input stalled with empty record register");

  a_error_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.tag_kind == KIND_INVALID |->
      !out_ch.is_key_frame && !out_ch.is_codec_header &&
      out_ch.payload_length == '0 && out_ch.absolute_time == '0)
    else $error("error record carries tag data");

  a_codec_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ch.is_codec_header |->
      out_ch.absolute_time == '0 && out_ch.is_key_frame &&
      (out_ch.tag_kind == KIND_AUDIO || out_ch.tag_kind == KIND_VIDEO))
    else $error("malformed codec header record");

endmodule

// File: tb/flvp_tag_checker.sv
module flvp_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  flvp_in_if          in_ch,
  flvp_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned records_checked,
  output int unsigned error_records
);
  timeunit 1ns;
  timeprecision 1ps;
  import flvp_pkg::*;

  // parser state as the byte stream walks through the file
  phase_t              cur_phase;
  logic [CNT_W-1:0]    phase_cnt;
  kind_t               cur_kind;
  logic [LEN_W-1:0]    cur_len;
  logic [TIME_W-1:0]   cur_time;
  logic [OFFSET_W-1:0] byte_pos;
  logic [7:0]          pay0;
  logic [7:0]          pay1;
  logic [COUNT_W-1:0]  audio_seen;
  logic [COUNT_W-1:0]  video_seen;
  logic                parse_halted;

  tag_rec_t tag_expect_q[$];

  function automatic string rec_text(input tag_rec_t r);
    return $sformatf("kind %0d len %0d time %h offset %h key %0b hdr %0b audio %0d video %0d",
                     r.kind, r.length, r.abs_time, r.offset, r.key, r.hdr,
                     r.audio_cnt, r.video_cnt);
  endfunction

  task automatic clear_parser();
    cur_phase    = PH_HEADER;
    phase_cnt    = '0;
    cur_kind     = KIND_AUDIO;
    cur_len      = '0;
    cur_time     = '0;
    byte_pos     = '0;
    pay0         = '0;
    pay1         = '0;
    audio_seen   = '0;
    video_seen   = '0;
    parse_halted = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic sof);
    tag_rec_t            rec;
    logic [OFFSET_W-1:0] here;
    if (sof) clear_parser();
    if (!parse_halted) begin
      here = byte_pos;
      byte_pos = byte_pos + 1'b1;
      rec = '0;
      case (cur_phase)
        PH_HEADER: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= HEADER_SKIP_BYTES) begin
            cur_phase = PH_TYPE;
            phase_cnt = '0;
          end
        end
        PH_TYPE: begin
          if (b == TYPE_AUDIO) begin
            cur_kind = KIND_AUDIO;
            audio_seen = audio_seen + 1'b1;
          end else if (b == TYPE_VIDEO) begin
            cur_kind = KIND_VIDEO;
            video_seen = video_seen + 1'b1;
          end else if (b == TYPE_SCRIPT) begin
            cur_kind = KIND_SCRIPT;
          end else begin
            // unknown type: error record at the type byte, then dead until a new file
            rec.kind = KIND_INVALID;
            rec.offset = here;
            rec.audio_cnt = audio_seen;
            rec.video_cnt = video_seen;
            tag_expect_q.push_back(rec);
            parse_halted = 1'b1;
          end
          if (!parse_halted) begin
            cur_len = '0;
            cur_time = '0;
            cur_phase = PH_LENGTH;
            phase_cnt = '0;
          end
        end
        PH_LENGTH: begin
          cur_len = {cur_len[15:0], b};
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= LENGTH_BYTES) begin
            cur_phase = PH_TIME;
            phase_cnt = '0;
          end
        end
        PH_TIME: begin
          if (phase_cnt < TIME_LOW_BYTES) cur_time = {8'h00, cur_time[15:0], b};
          else cur_time = {b, cur_time[23:0]};
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= TIME_BYTES) begin
            cur_phase = PH_STREAM;
            phase_cnt = '0;
          end
        end
        PH_STREAM: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= STREAM_BYTES) begin
            pay0 = '0;
            pay1 = '0;
            phase_cnt = '0;
            cur_phase = (cur_len == '0) ? PH_TRAILER : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (phase_cnt == 0) pay0 = b;
          else if (phase_cnt == 1) pay1 = b;
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= cur_len) begin
            cur_phase = PH_TRAILER;
            phase_cnt = '0;
          end
        end
        default: begin
          phase_cnt = phase_cnt + 1'b1;
          if (phase_cnt >= TRAILER_BYTES) begin
            rec.kind = cur_kind;
            rec.length = cur_len;
            rec.offset = here - 3 - cur_len;
            if (cur_kind == KIND_AUDIO) begin
              rec.key = 1'b1;
              rec.hdr = (pay0[7:4] == AAC_SOUND_FORMAT) && (pay1 == SEQ_HEADER_BYTE);
            end else if (cur_kind == KIND_VIDEO) begin
              rec.key = (pay0[7:4] == KEY_FRAME_TYPE);
              rec.hdr = rec.key && (pay0[3:0] == AVC_CODEC_ID) && (pay1 == SEQ_HEADER_BYTE);
            end
            // codec headers carry time zero
            rec.abs_time = rec.hdr ? '0 : cur_time;
            rec.audio_cnt = audio_seen;
            rec.video_cnt = video_seen;
            tag_expect_q.push_back(rec);
            cur_phase = PH_TYPE;
            phase_cnt = '0;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin : watch
    tag_rec_t got;
    tag_rec_t want;
    if (!rst_n) begin
      clear_parser();
      tag_expect_q.delete();
      fail_count = 0;
      records_checked = 0;
      error_records = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.kind      = kind_t'(out_ch.tag_kind);
        got.length    = out_ch.payload_length;
        got.abs_time  = out_ch.absolute_time;
        got.offset    = out_ch.payload_offset;
        got.key       = out_ch.is_key_frame;
        got.hdr       = out_ch.is_codec_header;
        got.audio_cnt = out_ch.audio_tag_count;
        got.video_cnt = out_ch.video_tag_count;
        if (tag_expect_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected record: %s", rec_text(got));
          fail_count++;
        end else begin
          want = tag_expect_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("record %0d mismatch", records_checked);
              $display("  expected %s", rec_text(want));
              $display("  actual   %s", rec_text(got));
            end
            fail_count++;
          end
          records_checked++;
          if (want.kind == KIND_INVALID) error_records++;
        end
      end
      // a record is registered after its last byte is taken, so input is handled after output
      if (in_ch.valid && in_ch.ready) parse_byte(in_ch.data_byte, in_ch.start_of_file);
    end
    pending = tag_expect_q.size();
  end

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import flvp_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       sof;
  } file_byte_t;

  logic clk;
  logic rst_n;

  flvp_in_if  in_ch();
  flvp_out_if out_ch();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned records_checked;
  int unsigned error_records;

  file_byte_t  file_bytes[$];
  int unsigned live_bytes;
  int unsigned tags_planned;
  logic        ignoring;

  flv_tag_header_parser #(.OFFSET_BITS(OFFSET_W)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  flvp_tag_checker i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .records_checked(records_checked),
    .error_records  (error_records)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
  end

  task automatic push_byte(input logic [7:0] b, input logic sof);
    file_bytes.push_back('{data: b, sof: sof});
    if (!ignoring) live_bytes++;
  endtask

  task automatic open_file(input int unsigned hdr_len);
    int unsigned k;
    ignoring = 1'b0;
    for (k = 0; k < hdr_len; k++) push_byte(8'($urandom()), k == 0);
  endtask

  task automatic put_tag_head(input logic [7:0] ttype, input logic [23:0] len,
                              input logic [31:0] ts);
    push_byte(ttype, 1'b0);
    push_byte(len[23:16], 1'b0);
    push_byte(len[15:8], 1'b0);
    push_byte(len[7:0], 1'b0);
    push_byte(ts[23:16], 1'b0);
    push_byte(ts[15:8], 1'b0);
    push_byte(ts[7:0], 1'b0);
    push_byte(ts[31:24], 1'b0);
    repeat (3) push_byte(8'($urandom()), 1'b0);
  endtask

  task automatic put_tag(input logic [7:0] ttype, input int unsigned len, input logic [31:0] ts,
                         input logic [7:0] p0, input logic [7:0] p1);
    int unsigned k;
    put_tag_head(ttype, 24'(len), ts);
    for (k = 0; k < len; k++) begin
      if (k == 0) push_byte(p0, 1'b0);
      else if (k == 1) push_byte(p1, 1'b0);
      else push_byte(8'($urandom()), 1'b0);
    end
    repeat (4) push_byte(8'($urandom()), 1'b0);
    tags_planned++;
  endtask

  // bad type byte, then some bytes the parser has to ignore
  task automatic put_bad_tag(input logic [7:0] b);
    int unsigned n;
    push_byte(b, 1'b0);
    tags_planned++;
    ignoring = 1'b1;
    n = $urandom_range(0, 20);
    repeat (n) push_byte(8'($urandom()), 1'b0);
  endtask

  function automatic logic [7:0] random_bad_type();
    logic [7:0] b;
    do b = 8'($urandom()); while (b == TYPE_AUDIO || b == TYPE_VIDEO || b == TYPE_SCRIPT);
    return b;
  endfunction

  task automatic put_random_tag();
    logic [7:0]  ttype;
    logic [7:0]  p0;
    logic [7:0]  p1;
    logic [31:0] ts;
    int unsigned len;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    ttype = (pick < 4) ? TYPE_AUDIO : (pick < 8) ? TYPE_VIDEO : TYPE_SCRIPT;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(0, 6);
    ts = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5000);
    case ($urandom_range(0, 3))
      0: p0 = {AAC_SOUND_FORMAT, 4'($urandom())};
      1: p0 = {KEY_FRAME_TYPE, AVC_CODEC_ID};
      2: p0 = {4'($urandom()), AVC_CODEC_ID};
      default: p0 = 8'($urandom());
    endcase
    p1 = $urandom_range(0, 1) ? SEQ_HEADER_BYTE : 8'($urandom());
    put_tag(ttype, len, ts, p0, p1);
  endtask

  task automatic build_file_stream();
    int unsigned sel;
    int unsigned n;
    live_bytes = 0;
    tags_planned = 0;
    ignoring = 1'b0;

    open_file(13);
    put_tag(TYPE_AUDIO, 4, 32'h0000_0001, {AAC_SOUND_FORMAT, 4'hf}, SEQ_HEADER_BYTE);
    put_tag(TYPE_AUDIO, 2, 32'h00ff_ffff, 8'haf, 8'h01);
    // one payload byte: the missing second byte reads as zero
    put_tag(TYPE_AUDIO, 1, 32'h0100_0000, 8'ha2, 8'hff);
    put_tag(TYPE_AUDIO, 0, 32'h0000_0000, 8'h00, 8'h00);
    put_tag(TYPE_VIDEO, 5, 32'hffff_ffff, {KEY_FRAME_TYPE, AVC_CODEC_ID}, SEQ_HEADER_BYTE);
    put_tag(TYPE_VIDEO, 3, 32'h8000_0000, 8'h17, 8'h01);
    put_tag(TYPE_VIDEO, 2, 32'h0000_0100, 8'h27, 8'h00);
    put_tag(TYPE_VIDEO, 2, 32'h0012_3456, 8'h12, 8'h00);
    put_tag(TYPE_VIDEO, 1, 32'h7f00_0001, 8'h17, 8'h55);
    put_tag(TYPE_VIDEO, 0, 32'h0000_00ff, 8'h00, 8'h00);
    put_tag(TYPE_SCRIPT, 6, 32'hffff_ffff, 8'ha0, 8'h00);
    put_tag(TYPE_SCRIPT, 0, 32'h0000_0000, 8'h17, 8'h00);
    put_bad_tag(8'hff);
    put_tag_head(TYPE_AUDIO, 24'd0, 32'h0);
    // new file while halted, restarted again in the middle of its header
    open_file(7);
    open_file(13);
    put_bad_tag(8'h00);
    open_file(13);
    put_tag(TYPE_AUDIO, 2, 32'h0000_0010, 8'h30, 8'h00);
    put_bad_tag(8'd7);
    open_file(13);
    // longest payload length, cut short by the next file
    put_tag_head(TYPE_VIDEO, 24'hff_ffff, 32'hffff_ffff);
    repeat (5) push_byte(8'($urandom()), 1'b0);
    open_file(13);
    put_bad_tag(8'd19);
    open_file(13);

    while (file_bytes.size() < 650) begin
      sel = $urandom_range(0, 99);
      if (sel < 84) begin
        put_random_tag();
      end else if (sel < 89) begin
        open_file(13);
      end else if (sel < 93) begin
        put_bad_tag(random_bad_type());
        open_file(13);
      end else if (sel < 96) begin
        put_tag_head(($urandom_range(0, 1) ? TYPE_AUDIO : TYPE_VIDEO),
                     24'($urandom_range(8, 24'hff_ffff)), $urandom());
        n = $urandom_range(0, 7);
        repeat (n) push_byte(8'($urandom()), 1'b0);
        open_file(13);
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) push_byte(8'($urandom()), $urandom_range(0, 7) == 0);
        open_file(13);
      end
    end
  endtask

  initial begin : result_sink
    int unsigned cyc;
    cyc = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      case ((cyc / 150) % 4)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = ($urandom_range(0, 9) < 7);
        2: out_ch.ready = ((cyc % 8) > 2);
        default: out_ch.ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    @(posedge rst_n);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d records still expected",
             IDLE_LIMIT, pending);
    $display("simulation failed");
    $finish;
  end

  initial begin : byte_source
    int unsigned k;
    int unsigned burst;
    int unsigned gap;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_file = 1'b0;
    build_file_stream();
    @(posedge rst_n);
    @(negedge clk);
    k = 0;
    while (k < file_bytes.size()) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      while (burst > 0 && k < file_bytes.size()) begin
        in_ch.valid = 1'b1;
        in_ch.data_byte = file_bytes[k].data;
        in_ch.start_of_file = file_bytes[k].sof;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        k++;
        burst--;
        @(negedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d file bytes (%0d past a bad type) holding %0d planned tags",
             file_bytes.size(), file_bytes.size() - live_bytes, tags_planned);
    $display("checked %0d tag records, %0d of them errors, mismatches: %0d",
             records_checked, error_records, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/flvp_pkg.sv
sv/flvp_ifs.sv
sv/flvp_core.sv
sv/flv_tag_header_parser.sv
tb/flvp_tag_checker.sv
tb/tb.sv
